// ===== rtl/ppe_pkg.sv =====
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared constants, types and helpers for the particle pool engine.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam int PoolSize = 64;
  localparam int SlotW = 6;
  localparam logic signed [31:0] OneQ = 32'sd65536;
  localparam logic signed [31:0] LifeFloor = -32'sd65536;
  localparam logic signed [31:0] ShrinkLimit = 32'sd6554;

  localparam logic OpSpawn = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef struct packed {
    logic clr_scan;
    logic adv_scan;
    logic spawn_wr;
    logic tick_rd;
    logic tick_wr;
    logic emit_tick;
    logic emit_spawn;
    logic last;
  } ppe_cmd_t;

  typedef struct packed {
    logic free_hit;
    logic scan_done;
    logic scan_end;
  } ppe_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // round(j * 65536 / 100) = floor((j * 16384 + 12) / 25), by reciprocal multiply
  function automatic logic [16:0] hundredths(input logic [6:0] j);
    logic [21:0] m;
    logic [43:0] p;
    begin
      m = {1'b0, j, 14'd0} + 22'd12;
      p = 44'(m) * 44'd2684355;
      hundredths = p[42:26];
    end
  endfunction

endpackage

// ===== rtl/ppe_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppe_ctrl
// Controller: sequences spawn search, one slot per cycle, and tick sweep, a read and a write state per slot.
// ----------------------------------------------------------------------------
module ppe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              opcode,
  input  ppe_pkg::ppe_stat_t stat,
  output logic              busy,
  output ppe_pkg::ppe_cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE, SEARCH, SPAWN, TRD, TWR
  } state_t;

  state_t state;
  logic   tick_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      tick_end <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            state <= (opcode == ppe_pkg::OpTick) ? TRD : SEARCH;
          end
        end
        SEARCH: begin
          if (stat.free_hit || stat.scan_done) begin
            state <= SPAWN;
          end
        end
        SPAWN: state <= IDLE;
        TRD: begin
          tick_end <= stat.scan_end;
          state <= TWR;
        end
        TWR: state <= tick_end ? IDLE : TRD;
        default: state <= IDLE;
      endcase
    end
  end

  assign busy = (state != IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      IDLE: cmd.clr_scan = start;
      SEARCH: cmd.adv_scan = !(stat.free_hit || stat.scan_done);
      SPAWN: begin
        cmd.spawn_wr = 1'b1;
        cmd.emit_spawn = 1'b1;
        cmd.last = 1'b1;
      end
      TRD: cmd.tick_rd = 1'b1;
      TWR: begin
        cmd.tick_wr = 1'b1;
        cmd.emit_tick = 1'b1;
        cmd.adv_scan = 1'b1;
        cmd.last = tick_end;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/ppe_datapath.sv =====
// ----------------------------------------------------------------------------
// ppe_datapath
// Particle stores, slot scanner, update arithmetic and result register.
// ----------------------------------------------------------------------------
module ppe_datapath #(
  parameter int POOL_SIZE = ppe_pkg::PoolSize
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ppe_pkg::ppe_cmd_t        cmd,
  output ppe_pkg::ppe_stat_t       stat,
  input  logic                     start,
  input  logic                     busy,
  input  logic [15:0]              delta,
  input  logic signed [31:0]       offset_x,
  input  logic signed [31:0]       offset_y,
  input  logic signed [31:0]       offset_z,
  input  logic [6:0]               jitter_x,
  input  logic [6:0]               jitter_y,
  input  logic [6:0]               jitter_z,
  input  logic [6:0]               shade,
  input  logic signed [4:0]        speed_x,
  input  logic signed [4:0]        speed_y,
  input  logic signed [4:0]        speed_z,
  output logic                     strobe,
  output logic [5:0]               slot,
  output logic                     alive,
  output logic signed [31:0]       place_x,
  output logic signed [31:0]       place_y,
  output logic signed [31:0]       place_z,
  output logic signed [31:0]       opacity,
  output logic [6:0]               brightness,
  output logic                     shrunk,
  output logic                     last
);

  localparam int SlotW = ppe_pkg::SlotW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(POOL_SIZE - 1);

  // live flags in flip-flops for the free search, values in memories
  logic signed [31:0] life_mem [POOL_SIZE];
  logic signed [31:0] px_mem [POOL_SIZE];
  logic signed [31:0] py_mem [POOL_SIZE];
  logic signed [31:0] pz_mem [POOL_SIZE];
  logic signed [31:0] al_mem [POOL_SIZE];
  logic [14:0]        vel_mem [POOL_SIZE];
  logic [6:0]         sh_mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] shrink_r;
  logic [POOL_SIZE-1:0] live_r;
  logic [POOL_SIZE-1:0] vld;

  logic [SlotW-1:0] ptr;
  logic [SlotW-1:0] idx;
  logic [SlotW:0]   cnt;
  logic [SlotW-1:0] pick;
  logic [SlotW-1:0] tslot;
  logic             tv;

  logic [15:0]        d_r;
  logic signed [31:0] ox, oy, oz;
  logic [6:0]         jx, jy, jz, sd;
  logic [14:0]        sp;

  logic signed [31:0] rd_px, rd_py, rd_pz, rd_al, rd_life;
  logic signed [21:0] mvx, mvy, mvz;
  logic signed [33:0] new_life;
  logic signed [31:0] life_sat;
  logic               live_now;
  logic signed [31:0] wpx, wpy, wpz, wal, npx, npy, npz;
  logic [18:0]        fade;

  assign stat.free_hit = !live_r[idx];
  assign stat.scan_done = (cnt == (SlotW+1)'(POOL_SIZE - 1));
  assign stat.scan_end = (tslot == LastSlot);

  always_comb begin
    pick = stat.free_hit ? idx : '0;
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      d_r <= delta;
      ox <= offset_x;
      oy <= offset_y;
      oz <= offset_z;
      jx <= jitter_x;
      jy <= jitter_y;
      jz <= jitter_z;
      sd <= shade;
      sp <= {speed_z, speed_y, speed_x};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      idx <= '0;
      cnt <= '0;
    end else if (cmd.clr_scan) begin
      idx <= ptr;
      cnt <= '0;
    end else if (cmd.adv_scan) begin
      idx <= (idx == LastSlot) ? '0 : idx + 1'b1;
      cnt <= cnt + 1'b1;
    end else if (cmd.spawn_wr) begin
      ptr <= pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tslot <= '0;
    end else if (cmd.clr_scan) begin
      tslot <= '0;
    end else if (cmd.tick_wr) begin
      tslot <= (tslot == LastSlot) ? '0 : tslot + 1'b1;
    end
  end

  // registered read for tick
  always_ff @(posedge clk) begin
    if (cmd.tick_rd) begin
      rd_px <= px_mem[tslot];
      rd_py <= py_mem[tslot];
      rd_pz <= pz_mem[tslot];
      rd_al <= al_mem[tslot];
      rd_life <= life_mem[tslot];
      mvx <= 22'(signed'(vel_mem[tslot][4:0])) * 22'(signed'({1'b0, d_r}));
      mvy <= 22'(signed'(vel_mem[tslot][9:5])) * 22'(signed'({1'b0, d_r}));
      mvz <= 22'(signed'(vel_mem[tslot][14:10])) * 22'(signed'({1'b0, d_r}));
    end
  end

  assign fade = ({3'd0, d_r} + {1'b0, d_r, 2'b00}) >> 1;
  assign new_life = 34'(tv ? rd_life : 32'sd0) - 34'(signed'({1'b0, d_r}));
  assign life_sat = (new_life < 34'(ppe_pkg::LifeFloor)) ? ppe_pkg::LifeFloor
                                                          : new_life[31:0];
  assign live_now = (life_sat > 32'sd0);
  assign npx = ppe_pkg::sat32(34'(rd_px) - 34'(mvx));
  assign npy = ppe_pkg::sat32(34'(rd_py) - 34'(mvy));
  assign npz = ppe_pkg::sat32(34'(rd_pz) - 34'(mvz));
  assign wal = live_now ? ppe_pkg::sat32(34'(rd_al) - 34'(signed'({1'b0, fade})))
                        : rd_al;
  assign wpx = live_now ? npx : rd_px;
  assign wpy = live_now ? npy : rd_py;
  assign wpz = live_now ? npz : rd_pz;

  logic signed [31:0] spx, spy, spz;
  assign spx = ppe_pkg::sat32(34'(ox) + 34'(signed'({1'b0, ppe_pkg::hundredths(jx)})));
  assign spy = ppe_pkg::sat32(34'(oy) + 34'(signed'({1'b0, ppe_pkg::hundredths(jy)})));
  assign spz = ppe_pkg::sat32(34'(oz) + 34'(signed'({1'b0, ppe_pkg::hundredths(jz)})));

  logic shrink_new;
  assign shrink_new = shrink_r[tslot] | (live_now && (life_sat < ppe_pkg::ShrinkLimit));

  always_ff @(posedge clk) begin
    if (cmd.spawn_wr) begin
      life_mem[pick] <= ppe_pkg::OneQ;
      px_mem[pick] <= spx;
      py_mem[pick] <= spy;
      pz_mem[pick] <= spz;
      al_mem[pick] <= ppe_pkg::OneQ;
      vel_mem[pick] <= sp;
      sh_mem[pick] <= sd;
    end else if (cmd.tick_wr) begin
      life_mem[tslot] <= life_sat;
      px_mem[tslot] <= wpx;
      py_mem[tslot] <= wpy;
      pz_mem[tslot] <= wpz;
      al_mem[tslot] <= wal;
    end
  end

  // reset values: valid, live and shrink flags in flip-flops; unspawned slots emit zeros
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      live_r <= '0;
      shrink_r <= '0;
    end else if (cmd.spawn_wr) begin
      vld[pick] <= 1'b1;
      live_r[pick] <= 1'b1;
      shrink_r[pick] <= 1'b0;
    end else if (cmd.tick_wr) begin
      live_r[tslot] <= live_now;
      shrink_r[tslot] <= shrink_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_rd) begin
      tv <= vld[tslot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_spawn | cmd.emit_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_spawn) begin
      slot <= pick;
      alive <= 1'b1;
      place_x <= spx;
      place_y <= spy;
      place_z <= spz;
      opacity <= ppe_pkg::OneQ;
      brightness <= sd;
      shrunk <= 1'b0;
      last <= 1'b1;
    end else if (cmd.emit_tick) begin
      slot <= tslot;
      alive <= live_now;
      place_x <= tv ? wpx : '0;
      place_y <= tv ? wpy : '0;
      place_z <= tv ? wpz : '0;
      opacity <= tv ? wal : '0;
      brightness <= tv ? sh_mem[tslot] : '0;
      shrunk <= shrink_new;
      last <= cmd.last;
    end
  end

endmodule

// ===== rtl/particle_pool_engine_core.sv =====
// ----------------------------------------------------------------------------
// particle_pool_engine_core
// Particle pool with next-fit spawn and per-tick life, motion and fade update.
// ----------------------------------------------------------------------------
// Spawn: the search scans k slots from the next-fit pointer, k = 1 to POOL_SIZE,
//   then SPAWN writes the chosen slot; a new operation is taken only when idle.
// Tick: sweeps every slot in order, a read state and a write state per slot,
//   one result per slot.
// Results show in the cycle after each write; the receiver cannot stall.
// Synchronous reset empties the pool; busy is low right after reset.
module particle_pool_engine_core #(
  parameter int POOL_SIZE = ppe_pkg::PoolSize
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic [15:0]        delta,
  input  logic signed [31:0] offset_x,
  input  logic signed [31:0] offset_y,
  input  logic signed [31:0] offset_z,
  input  logic [6:0]         jitter_x,
  input  logic [6:0]         jitter_y,
  input  logic [6:0]         jitter_z,
  input  logic [6:0]         shade,
  input  logic signed [4:0]  speed_x,
  input  logic signed [4:0]  speed_y,
  input  logic signed [4:0]  speed_z,
  output logic               strobe,
  output logic [5:0]         slot,
  output logic               alive,
  output logic signed [31:0] place_x,
  output logic signed [31:0] place_y,
  output logic signed [31:0] place_z,
  output logic signed [31:0] opacity,
  output logic [6:0]         brightness,
  output logic               shrunk,
  output logic               last
);

  ppe_pkg::ppe_cmd_t  cmd;
  ppe_pkg::ppe_stat_t stat;

  ppe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode),
    .stat(stat), .busy(busy), .cmd(cmd)
  );

  ppe_datapath #(.POOL_SIZE(POOL_SIZE)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .start(start), .busy(busy),
    .delta(delta), .offset_x(offset_x), .offset_y(offset_y), .offset_z(offset_z),
    .jitter_x(jitter_x), .jitter_y(jitter_y), .jitter_z(jitter_z), .shade(shade),
    .speed_x(speed_x), .speed_y(speed_y), .speed_z(speed_z),
    .strobe(strobe), .slot(slot), .alive(alive), .place_x(place_x),
    .place_y(place_y), .place_z(place_z), .opacity(opacity),
    .brightness(brightness), .shrunk(shrunk), .last(last)
  );

endmodule
